@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A plain property under the block clock and reset.
`define CST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its condition.
`define CST_ASSERT_IMPL(lbl, cond, cons, msg) \
	`CST_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

@@ hw/rtl/cst_pkg.sv @@
package cst_pkg;

	// Port and payload widths.
	localparam int MOTOR_W  = 2;
	localparam int TIME_W   = 16;
	localparam int POS_W    = 12;
	localparam int CFG_IDX_W = 3;

	// Internal datapath widths.
	localparam int NUM_W    = 24;  // signed progress numerator in time ticks
	localparam int DIV_W    = 24;  // dividend of the reciprocal division
	localparam int QEST_W   = 16;  // quotient estimate before correction
	localparam int P_FRAC   = 16;  // fraction bits of p and s
	localparam int P_W      = 17;  // p and s, with 1.0 representable
	localparam int PP_W     = 33;  // p squared
	localparam int LIN_W    = 18;  // 3 - 2p in Q.16
	localparam int NSTG     = 6;   // pipeline depth

	localparam logic [MOTOR_W-1:0] MOTOR_LAST = 2'd3;
	localparam logic [P_W-1:0]     Q16_ONE    = 17'h10000;
	localparam logic [LIN_W-1:0]   LIN_BASE   = 18'h30000;

	// Low bit of a register index picks the min or the max table.
	localparam logic CFG_SEL_MIN = 1'b0;
	localparam logic CFG_SEL_MAX = 1'b1;

	// How the progress value of an item is formed.
	typedef enum logic [1:0] {
		PK_ZERO,
		PK_FULL,
		PK_FRAC
	} prog_kind_t;

endpackage

@@ hw/rtl/cascaded_smoothstep_trajectory.sv @@
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    motor_sel, time_now
// out      source     out_valid / out_ready  position
// cfg      sink       cfg_wr_en              cfg_index, cfg_data
//
// Throughput is one beat per cycle while out_ready holds high; a low out_ready stalls the pipeline.
// The pipeline has six registers: numerator, reciprocal multiply,
// correction, square, cubic multiply and final scaling.
// arst_n clears all stage valid bits and loads min/max positions with 0 and 4095.
// A stage holds its beat while the stage after it is full and stalled; empty stages fill.
`include "assert_macros.svh"

module cascaded_smoothstep_trajectory #(
	parameter int CASCADE_STEP   = 7,
	parameter int RAMP_LENGTH    = 55,
	parameter int MID_PAUSE      = 5,
	parameter int TIME_FRAC_BITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cst_pkg::MOTOR_W-1:0]   motor_sel,
	input  logic [cst_pkg::TIME_W-1:0]    time_now,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cst_pkg::POS_W-1:0]     position,
	input  logic                          cfg_wr_en,
	input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cst_pkg::POS_W-1:0]     cfg_data
);

	localparam int NUM_W    = cst_pkg::NUM_W;
	localparam int DIV_W    = cst_pkg::DIV_W;
	localparam int NSTG     = cst_pkg::NSTG;
	localparam int SCALE    = 1 << TIME_FRAC_BITS;
	localparam int STEP_T   = CASCADE_STEP * SCALE;
	localparam int STEP2_T  = 2 * STEP_T;
	localparam int RAMP_T   = RAMP_LENGTH * SCALE;
	localparam int RAMP2_T  = 2 * RAMP_T;
	localparam int TOTAL_T  = (2 * RAMP_LENGTH + 6 * CASCADE_STEP + MID_PAUSE) * SCALE;
	localparam int SH_OPEN  = cst_pkg::P_FRAC - TIME_FRAC_BITS;
	localparam int SH_CLOSE = SH_OPEN - 1;
	localparam int RECIP    = (1 << DIV_W) / RAMP_LENGTH;
	localparam int RECIP_W  = DIV_W + 1;
	localparam int PROD2_W  = DIV_W + RECIP_W;
	localparam int PROD5_W  = cst_pkg::PP_W + cst_pkg::LIN_W;
	localparam int DIFF_W   = cst_pkg::POS_W + 1;
	localparam int PROD6_W  = DIFF_W + cst_pkg::P_W + 1;

	// Configuration registers.
	logic [cst_pkg::POS_W-1:0] min_pos_q [4];
	logic [cst_pkg::POS_W-1:0] max_pos_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				min_pos_q[k] <= '0;
				max_pos_q[k] <= '1;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index[0])
				cst_pkg::CFG_SEL_MIN: min_pos_q[cfg_index[2:1]] <= cfg_data;
				cst_pkg::CFG_SEL_MAX: max_pos_q[cfg_index[2:1]] <= cfg_data;
			endcase
		end
	end

	// Stage handshake: a stage loads when it is empty or its successor loads.
	logic [NSTG:1] vld;
	logic [NSTG:1] rdy;
	logic [NSTG:1] ld;

	always_comb begin
		rdy[NSTG] = !vld[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
		ld[1] = in_valid && rdy[1];
		for (int k = 2; k <= NSTG; k++) begin
			ld[k] = vld[k-1] && rdy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) vld[k] <= vld[k-1];
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld[NSTG];

	// Stage 1: phase select, progress numerator and clamp classification.
	logic [NUM_W-1:0]           t_ext, t_dbl, dly_open, lim_close;
	logic [NUM_W-1:0]           num_open, num_close, num_sel, den_sel;
	logic                       closing;
	cst_pkg::prog_kind_t        kind_c1;
	logic [DIV_W-1:0]           dvd_c1;

	always_comb begin
		t_ext     = NUM_W'(time_now);
		t_dbl     = t_ext << 1;
		closing   = t_dbl >= NUM_W'(TOTAL_T);
		dly_open  = NUM_W'(STEP_T) * NUM_W'(cst_pkg::MOTOR_LAST - motor_sel);
		lim_close = NUM_W'(TOTAL_T + RAMP2_T) + NUM_W'(STEP2_T) * NUM_W'(motor_sel);
		num_open  = t_ext - dly_open;
		num_close = lim_close - t_dbl;
		num_sel   = closing ? num_close : num_open;
		den_sel   = closing ? NUM_W'(RAMP2_T) : NUM_W'(RAMP_T);
		if (num_sel[NUM_W-1] || num_sel == '0) begin
			kind_c1 = cst_pkg::PK_ZERO;
		end else if (num_sel >= den_sel) begin
			kind_c1 = cst_pkg::PK_FULL;
		end else begin
			kind_c1 = cst_pkg::PK_FRAC;
		end
		// Scale so that a plain divide by the ramp length yields Q0.16.
		dvd_c1 = closing ? DIV_W'(num_sel << SH_CLOSE) : DIV_W'(num_sel << SH_OPEN);
	end

	logic [DIV_W-1:0]             dvd_s1, dvd_s2;
	cst_pkg::prog_kind_t          kind_s1, kind_s2;
	logic [cst_pkg::MOTOR_W-1:0]  motor_s1, motor_s2, motor_s3, motor_s4, motor_s5;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dvd_s1   <= dvd_c1;
			kind_s1  <= kind_c1;
			motor_s1 <= motor_sel;
		end
	end

	// Stage 2: quotient estimate by multiplying with the reciprocal of the ramp.
	logic [PROD2_W-1:0]              prod_c2;
	logic [cst_pkg::QEST_W-1:0]      qest_s2;

	assign prod_c2 = PROD2_W'(dvd_s1) * PROD2_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			qest_s2  <= prod_c2[DIV_W +: cst_pkg::QEST_W];
			dvd_s2   <= dvd_s1;
			kind_s2  <= kind_s1;
			motor_s2 <= motor_s1;
		end
	end

	// Stage 3: the estimate is low by at most one; fix it and apply the clamp.
	logic [DIV_W-1:0]       rem_c3;
	logic [cst_pkg::P_W-1:0] pfrac_c3, p_c3, p_s3;

	always_comb begin
		rem_c3   = dvd_s2 - DIV_W'(qest_s2) * DIV_W'(RAMP_LENGTH);
		pfrac_c3 = cst_pkg::P_W'(qest_s2) + cst_pkg::P_W'(rem_c3 >= DIV_W'(RAMP_LENGTH));
		case (kind_s2)
			cst_pkg::PK_ZERO: p_c3 = '0;
			cst_pkg::PK_FULL: p_c3 = cst_pkg::Q16_ONE;
			cst_pkg::PK_FRAC: p_c3 = pfrac_c3;
			default:          p_c3 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			p_s3     <= p_c3;
			motor_s3 <= motor_s2;
		end
	end

	// Stage 4: p squared and the linear term 3 - 2p.
	logic [cst_pkg::PP_W-1:0]  pp_s4;
	logic [cst_pkg::LIN_W-1:0] lin_s4;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			pp_s4    <= cst_pkg::PP_W'(p_s3) * cst_pkg::PP_W'(p_s3);
			lin_s4   <= cst_pkg::LIN_BASE - {p_s3, 1'b0};
			motor_s4 <= motor_s3;
		end
	end

	// Stage 5: smoothstep value, truncated back to Q0.16.
	logic [PROD5_W-1:0]      prod_c5;
	logic [cst_pkg::P_W-1:0] s_s5;

	assign prod_c5 = PROD5_W'(pp_s4) * PROD5_W'(lin_s4);

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			s_s5     <= prod_c5[2*cst_pkg::P_FRAC +: cst_pkg::P_W];
			motor_s5 <= motor_s4;
		end
	end

	// Stage 6: scale the signed span by s with a floor shift, offset from max.
	logic signed [DIFF_W-1:0]  diff_c6;
	logic signed [PROD6_W-1:0] prod_c6, shr_c6;
	logic [cst_pkg::POS_W-1:0] pos_c6, position_s6;

	always_comb begin
		diff_c6 = $signed({1'b0, max_pos_q[motor_s5]}) - $signed({1'b0, min_pos_q[motor_s5]});
		prod_c6 = PROD6_W'(diff_c6) * $signed({1'b0, s_s5});
		shr_c6  = prod_c6 >>> cst_pkg::P_FRAC;
		pos_c6  = max_pos_q[motor_s5] - shr_c6[cst_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			position_s6 <= pos_c6;
		end
	end

	assign position = position_s6;

	// Checks on the datapath and the stall network.
	`CST_ASSERT_IMPL(a_rem_below_two_ramps, vld[2] && kind_s2 == cst_pkg::PK_FRAC,
		rem_c3 < DIV_W'(2 * RAMP_LENGTH), "reciprocal estimate off by more than one")
	`CST_ASSERT_IMPL(a_progress_range, vld[3], p_s3 <= cst_pkg::Q16_ONE,
		"progress above one")
	`CST_ASSERT_IMPL(a_smooth_range, vld[5], s_s5 <= cst_pkg::Q16_ONE,
		"smoothstep above one")
	`CST_ASSERT_IMPL(a_ready_when_drained, !vld[NSTG] && !vld[1], in_ready,
		"input blocked with room in the pipeline")

endmodule
